/* src/kvlt_pkg.sv */
`default_nettype none
package kvlt_pkg;

  localparam int KEY_CAPACITY   = 32;
  localparam int VALUE_CAPACITY = 64;

  // Configuration register indexes.
  localparam logic REG_KEY_LIMIT   = 1'b0;
  localparam logic REG_VALUE_LIMIT = 1'b1;

  localparam int CFG_DATA_W = 6;

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_NONE     = 3'd0;
  localparam kind_t KIND_KEY      = 3'd1;
  localparam kind_t KIND_VALUE    = 3'd2;
  localparam kind_t KIND_PAIR     = 3'd3;
  localparam kind_t KIND_LINE_OK  = 3'd4;
  localparam kind_t KIND_LINE_BAD = 3'd5;
  localparam kind_t KIND_OVERFLOW = 3'd6;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_line_end(input logic [7:0] c);
    return c == CH_NUL || c == CH_CR || c == CH_LF;
  endfunction

endpackage
`default_nettype wire

/* src/kvlt_if.sv */
`default_nettype none
interface kvlt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface kvlt_result_if;
  logic                valid;
  logic                ready;
  kvlt_pkg::kind_t     kind;
  logic [7:0]          byte_out;
  logic [5:0]          position;

  modport source (output valid, output kind, output byte_out, output position, input ready);
  modport sink (input valid, input kind, input byte_out, input position, output ready);
endinterface
`default_nettype wire

/* src/key_value_line_tokenizer.sv */
// A result is presented in the cycle after its byte is accepted.
// Throughput: one byte per cycle; every byte yields exactly one result.
// The single result register sets the rate: a new byte is taken whenever the
// register is empty or its result is taken in the same cycle.
// Reset (rst, synchronous) clears the tokenizer state, empties the result
// register and sets key_limit to 31 and value_limit to 63.
`default_nettype none
module key_value_line_tokenizer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [kvlt_pkg::CFG_DATA_W-1:0] cfg_data,
  kvlt_byte_if.sink                            byte_ch,
  kvlt_result_if.source                        result_ch
);

  typedef enum logic [3:0] {
    TK_START    = 4'd0,
    TK_QUOTE    = 4'd1,
    TK_COLON    = 4'd2,
    TK_COMMA    = 4'd3,
    TK_LCURLY   = 4'd4,
    TK_RCURLY   = 4'd5,
    TK_LBRACKET = 4'd6,
    TK_RBRACKET = 4'd7,
    TK_LETTER   = 4'd8
  } expect_t;

  typedef enum logic [3:0] {
    ST_INDET       = 4'd0,
    ST_NEW         = 4'd1,
    ST_KEY         = 4'd2,
    ST_KEY_BEGIN   = 4'd3,
    ST_KEY_END     = 4'd4,
    ST_VALUE       = 4'd5,
    ST_VALUE_BEGIN = 4'd6,
    ST_VALUE_END   = 4'd7,
    ST_END         = 4'd8
  } stage_t;

  typedef enum logic [1:0] {
    VD_INDET = 2'd0,
    VD_TRUE  = 2'd1,
    VD_FALSE = 2'd2
  } verdict_t;

  localparam logic [5:0] KEY_MAX   = 6'(kvlt_pkg::KEY_CAPACITY - 1);
  localparam logic [6:0] VALUE_MAX = 7'(kvlt_pkg::VALUE_CAPACITY - 1);

  function automatic stage_t next_stage(input stage_t s);
    stage_t r;
    unique case (s)
      ST_INDET:       r = ST_NEW;
      ST_NEW:         r = ST_KEY;
      ST_KEY:         r = ST_KEY_BEGIN;
      ST_KEY_BEGIN:   r = ST_KEY_END;
      ST_KEY_END:     r = ST_VALUE;
      ST_VALUE:       r = ST_VALUE_BEGIN;
      ST_VALUE_BEGIN: r = ST_VALUE_END;
      ST_VALUE_END:   r = ST_NEW;
      default:        r = ST_INDET;
    endcase
    return r;
  endfunction

  logic [4:0] key_limit;
  logic [5:0] value_limit;

  expect_t    expect_token, expect_token_next;
  stage_t     object_stage, object_stage_next;
  verdict_t   verdict, verdict_next;
  logic       nested_flag, nested_flag_next;
  logic [5:0] key_count, key_count_next;
  logic [6:0] value_count, value_count_next;

  logic            res_valid;
  kvlt_pkg::kind_t res_kind, res_kind_next;
  logic [7:0]      res_byte, res_byte_next;
  logic [5:0]      res_pos, res_pos_next;

  logic       accept;
  logic [7:0] c;
  logic [5:0] key_lim;
  logic [6:0] value_lim;

  assign c         = byte_ch.byte_in;
  assign byte_ch.ready = !res_valid || result_ch.ready;
  assign accept    = byte_ch.valid && byte_ch.ready;

  assign key_lim   = ({1'b0, key_limit} > KEY_MAX) ? KEY_MAX : {1'b0, key_limit};
  assign value_lim = ({1'b0, value_limit} > VALUE_MAX) ? VALUE_MAX : {1'b0, value_limit};

  assign result_ch.valid    = res_valid;
  assign result_ch.kind     = res_kind;
  assign result_ch.byte_out = res_byte;
  assign result_ch.position = res_pos;

  always_comb begin
    expect_token_next = expect_token;
    object_stage_next = object_stage;
    verdict_next      = verdict;
    nested_flag_next  = nested_flag;
    key_count_next    = key_count;
    value_count_next  = value_count;
    res_kind_next     = kvlt_pkg::KIND_NONE;
    res_byte_next     = '0;
    res_pos_next      = '0;

    // Token transition.
    unique case (expect_token)
      TK_QUOTE: begin
        if (c == kvlt_pkg::CH_COLON || c == kvlt_pkg::CH_COMMA) begin
          expect_token_next = (c == kvlt_pkg::CH_COLON) ? TK_COLON : TK_COMMA;
          if (nested_flag) begin
            verdict_next = VD_TRUE;
          end else begin
            object_stage_next = next_stage(object_stage);
            verdict_next      = VD_INDET;
          end
        end else if (c == kvlt_pkg::CH_RCURLY || c == kvlt_pkg::CH_RBRACK) begin
          expect_token_next = (c == kvlt_pkg::CH_RCURLY) ? TK_RCURLY : TK_RBRACKET;
          object_stage_next = next_stage(object_stage);
          verdict_next      = VD_INDET;
          nested_flag_next  = 1'b0;
        end else if (kvlt_pkg::is_line_end(c)) begin
          verdict_next      = VD_TRUE;
          object_stage_next = ST_END;
        end else if (kvlt_pkg::is_alnum(c)) begin
          expect_token_next = TK_LETTER;
          verdict_next      = VD_TRUE;
          if (object_stage == ST_KEY) begin
            object_stage_next = ST_KEY_BEGIN;
          end else if (object_stage == ST_VALUE) begin
            object_stage_next = ST_VALUE_BEGIN;
          end
        end else begin
          verdict_next = VD_FALSE;
        end
      end
      TK_COLON: begin
        if (c == kvlt_pkg::CH_QUOTE) begin
          expect_token_next = TK_QUOTE;
          verdict_next      = nested_flag ? VD_TRUE : VD_INDET;
        end else if (c == kvlt_pkg::CH_LCURLY || c == kvlt_pkg::CH_LBRACK) begin
          expect_token_next = (c == kvlt_pkg::CH_LCURLY) ? TK_LCURLY : TK_LBRACKET;
          nested_flag_next  = 1'b1;
          object_stage_next = next_stage(object_stage);
          verdict_next      = VD_INDET;
        end else begin
          verdict_next = VD_FALSE;
        end
      end
      TK_COMMA: begin
        if (c == kvlt_pkg::CH_QUOTE) begin
          expect_token_next = TK_QUOTE;
          if (nested_flag) begin
            verdict_next = VD_TRUE;
          end else begin
            object_stage_next = next_stage(object_stage);
            verdict_next      = VD_INDET;
          end
        end else begin
          verdict_next = VD_FALSE;
        end
      end
      TK_LCURLY, TK_LBRACKET: begin
        if (c == kvlt_pkg::CH_QUOTE) begin
          expect_token_next = TK_QUOTE;
          if (nested_flag) begin
            verdict_next = VD_TRUE;
          end
        end else begin
          verdict_next = VD_FALSE;
        end
      end
      TK_RCURLY, TK_RBRACKET: begin
        if (c == kvlt_pkg::CH_COMMA ||
            (c == kvlt_pkg::CH_RCURLY && expect_token == TK_RBRACKET)) begin
          expect_token_next = (c == kvlt_pkg::CH_COMMA) ? TK_COMMA : TK_RCURLY;
          nested_flag_next  = 1'b0;
          verdict_next      = VD_INDET;
          object_stage_next = next_stage(object_stage);
        end else if (kvlt_pkg::is_line_end(c)) begin
          verdict_next      = VD_TRUE;
          object_stage_next = (expect_token == TK_RCURLY) ? ST_INDET : ST_END;
        end else begin
          verdict_next = VD_FALSE;
        end
      end
      TK_LETTER: begin
        if (c == kvlt_pkg::CH_QUOTE) begin
          expect_token_next = TK_QUOTE;
          if (nested_flag) begin
            verdict_next = VD_TRUE;
          end else begin
            object_stage_next = next_stage(object_stage);
          end
        end else if (kvlt_pkg::is_alnum(c)) begin
          verdict_next = VD_TRUE;
        end else begin
          verdict_next = VD_FALSE;
        end
      end
      default: begin
        // Start of line, and any code that is not a token.
        if (c == kvlt_pkg::CH_QUOTE) begin
          expect_token_next = TK_QUOTE;
          verdict_next      = VD_INDET;
          object_stage_next = next_stage(object_stage);
        end else begin
          verdict_next = VD_FALSE;
        end
      end
    endcase

    // Result selection on the post-transition state.
    if (c == kvlt_pkg::CH_LF) begin
      res_kind_next     = (verdict_next == VD_TRUE) ? kvlt_pkg::KIND_LINE_OK
                                                    : kvlt_pkg::KIND_LINE_BAD;
      expect_token_next = TK_START;
      object_stage_next = ST_NEW;
      verdict_next      = VD_INDET;
      nested_flag_next  = 1'b0;
      key_count_next    = '0;
      value_count_next  = '0;
    end else begin
      if (object_stage_next == ST_KEY) begin
        key_count_next   = '0;
        value_count_next = '0;
      end
      if (object_stage_next == ST_VALUE_END) begin
        res_kind_next = kvlt_pkg::KIND_PAIR;
      end else if (verdict_next == VD_TRUE && object_stage_next == ST_KEY_BEGIN) begin
        res_byte_next = c;
        res_pos_next  = key_count;
        if (key_count < key_lim) begin
          res_kind_next  = kvlt_pkg::KIND_KEY;
          key_count_next = key_count + 6'd1;
        end else begin
          res_kind_next = kvlt_pkg::KIND_OVERFLOW;
        end
      end else if (verdict_next == VD_TRUE && object_stage_next == ST_VALUE_BEGIN) begin
        res_byte_next = c;
        res_pos_next  = value_count[5:0];
        if (value_count < value_lim) begin
          res_kind_next    = kvlt_pkg::KIND_VALUE;
          value_count_next = value_count + 7'd1;
        end else begin
          res_kind_next = kvlt_pkg::KIND_OVERFLOW;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_limit    <= 5'd31;
      value_limit  <= 6'd63;
      expect_token <= TK_START;
      object_stage <= ST_NEW;
      verdict      <= VD_INDET;
      nested_flag  <= 1'b0;
      key_count    <= '0;
      value_count  <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          kvlt_pkg::REG_KEY_LIMIT:   key_limit   <= cfg_data[4:0];
          kvlt_pkg::REG_VALUE_LIMIT: value_limit <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        expect_token <= expect_token_next;
        object_stage <= object_stage_next;
        verdict      <= verdict_next;
        nested_flag  <= nested_flag_next;
        key_count    <= key_count_next;
        value_count  <= value_count_next;
        res_valid    <= 1'b1;
      end else if (result_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_kind <= res_kind_next;
      res_byte <= res_byte_next;
      res_pos  <= res_pos_next;
    end
  end

`ifndef SYNTHESIS
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_kind != 3'd7))
    else $error("result kind out of range");

  a_key_count_cap: assert property (@(posedge clk) disable iff (rst)
    key_count <= KEY_MAX && value_count <= VALUE_MAX)
    else $error("key or value count beyond capacity");

  a_lf_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && c == kvlt_pkg::CH_LF) |=>
      (expect_token == TK_START && object_stage == ST_NEW && !nested_flag &&
       key_count == 6'd0 && value_count == 7'd0))
    else $error("line feed did not clear the tokenizer");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted byte produced no result");
`endif

endmodule
`default_nettype wire

/* bench/key_value_line_tokenizer_tb.sv */
`timescale 1ns / 1ps
module key_value_line_tokenizer_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [3:0] {
    TK_START, TK_QUOTE, TK_COLON, TK_COMMA, TK_LCURLY, TK_RCURLY,
    TK_LBRACKET, TK_RBRACKET, TK_LETTER
  } expect_t;

  typedef enum logic [3:0] {
    ST_INDET, ST_NEW, ST_KEY, ST_KEY_BEGIN, ST_KEY_END, ST_VALUE,
    ST_VALUE_BEGIN, ST_VALUE_END, ST_END
  } stage_t;

  typedef enum logic [1:0] {VD_INDET, VD_TRUE, VD_FALSE} verdict_t;

  typedef struct packed {
    kvlt_pkg::kind_t kind;
    logic [7:0]      data;
    logic [5:0]      pos;
  } token_t;

  class tokenizer_scoreboard;
    logic [4:0] key_limit;
    logic [5:0] value_limit;
    expect_t    tok;
    stage_t     stage;
    verdict_t   verdict;
    logic       nested;
    logic [5:0] key_count;
    logic [6:0] value_count;
    token_t     pending_tokens[$];
    int         errors;

    function new();
      key_limit   = 5'd31;
      value_limit = 6'd63;
      errors      = 0;
      clear_line();
    endfunction

    function void clear_line();
      tok         = TK_START;
      stage       = ST_NEW;
      verdict     = VD_INDET;
      nested      = 1'b0;
      key_count   = '0;
      value_count = '0;
    endfunction

    function void set_limit(logic idx, logic [5:0] v);
      if (idx == kvlt_pkg::REG_KEY_LIMIT) key_limit = v[4:0];
      else value_limit = v;
    endfunction

    function bit word_byte(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function bit ends_token(logic [7:0] c);
      return c == kvlt_pkg::CH_NUL || c == kvlt_pkg::CH_CR || c == kvlt_pkg::CH_LF;
    endfunction

    function stage_t next_of(stage_t s);
      case (s)
        ST_INDET:       return ST_NEW;
        ST_NEW:         return ST_KEY;
        ST_KEY:         return ST_KEY_BEGIN;
        ST_KEY_BEGIN:   return ST_KEY_END;
        ST_KEY_END:     return ST_VALUE;
        ST_VALUE:       return ST_VALUE_BEGIN;
        ST_VALUE_BEGIN: return ST_VALUE_END;
        ST_VALUE_END:   return ST_NEW;
        default:        return ST_INDET;
      endcase
    endfunction

    // Inside a nested value a separator keeps the verdict true so that it
    // passes through as a raw value byte.
    function void open_or_nested(bit adv);
      if (nested) begin
        verdict = VD_TRUE;
      end else begin
        if (adv) stage = next_of(stage);
        verdict = VD_INDET;
      end
    endfunction

    function void advance_token(logic [7:0] c);
      case (tok)
        TK_QUOTE: begin
          if (c == kvlt_pkg::CH_COLON || c == kvlt_pkg::CH_COMMA) begin
            if (c == kvlt_pkg::CH_COLON) tok = TK_COLON;
            else tok = TK_COMMA;
            open_or_nested(1'b1);
          end else if (c == kvlt_pkg::CH_RCURLY || c == kvlt_pkg::CH_RBRACK) begin
            if (c == kvlt_pkg::CH_RCURLY) tok = TK_RCURLY;
            else tok = TK_RBRACKET;
            stage   = next_of(stage);
            verdict = VD_INDET;
            nested  = 1'b0;
          end else if (ends_token(c)) begin
            verdict = VD_TRUE;
            stage   = ST_END;
          end else if (word_byte(c)) begin
            tok     = TK_LETTER;
            verdict = VD_TRUE;
            if (stage == ST_KEY) stage = ST_KEY_BEGIN;
            else if (stage == ST_VALUE) stage = ST_VALUE_BEGIN;
          end else begin
            verdict = VD_FALSE;
          end
        end
        TK_COLON: begin
          if (c == kvlt_pkg::CH_QUOTE) begin
            tok = TK_QUOTE;
            open_or_nested(1'b0);
          end else if (c == kvlt_pkg::CH_LCURLY || c == kvlt_pkg::CH_LBRACK) begin
            if (c == kvlt_pkg::CH_LCURLY) tok = TK_LCURLY;
            else tok = TK_LBRACKET;
            nested  = 1'b1;
            stage   = next_of(stage);
            verdict = VD_INDET;
          end else begin
            verdict = VD_FALSE;
          end
        end
        TK_COMMA: begin
          if (c == kvlt_pkg::CH_QUOTE) begin
            tok = TK_QUOTE;
            open_or_nested(1'b1);
          end else begin
            verdict = VD_FALSE;
          end
        end
        TK_LCURLY, TK_LBRACKET: begin
          if (c == kvlt_pkg::CH_QUOTE) begin
            tok = TK_QUOTE;
            if (nested) verdict = VD_TRUE;
          end else begin
            verdict = VD_FALSE;
          end
        end
        TK_RCURLY, TK_RBRACKET: begin
          if (c == kvlt_pkg::CH_COMMA ||
              (c == kvlt_pkg::CH_RCURLY && tok == TK_RBRACKET)) begin
            if (c == kvlt_pkg::CH_COMMA) tok = TK_COMMA;
            else tok = TK_RCURLY;
            nested  = 1'b0;
            verdict = VD_INDET;
            stage   = next_of(stage);
          end else if (ends_token(c)) begin
            verdict = VD_TRUE;
            if (tok == TK_RCURLY) stage = ST_INDET;
            else stage = ST_END;
          end else begin
            verdict = VD_FALSE;
          end
        end
        TK_LETTER: begin
          if (c == kvlt_pkg::CH_QUOTE) begin
            tok = TK_QUOTE;
            if (nested) verdict = VD_TRUE;
            else stage = next_of(stage);
          end else if (word_byte(c)) begin
            verdict = VD_TRUE;
          end else begin
            verdict = VD_FALSE;
          end
        end
        default: begin
          if (c == kvlt_pkg::CH_QUOTE) begin
            tok     = TK_QUOTE;
            verdict = VD_INDET;
            stage   = next_of(stage);
          end else begin
            verdict = VD_FALSE;
          end
        end
      endcase
    endfunction

    function token_t tokenize_byte(logic [7:0] c);
      token_t     r;
      logic [5:0] klim;
      logic [6:0] vlim;
      r = '0;
      advance_token(c);
      if (c == kvlt_pkg::CH_LF) begin
        r.kind = (verdict == VD_TRUE) ? kvlt_pkg::KIND_LINE_OK : kvlt_pkg::KIND_LINE_BAD;
        clear_line();
      end else begin
        if (stage == ST_KEY) begin
          key_count   = '0;
          value_count = '0;
        end
        if (stage == ST_VALUE_END) begin
          r.kind = kvlt_pkg::KIND_PAIR;
        end else if (verdict == VD_TRUE && stage == ST_KEY_BEGIN) begin
          klim = ({1'b0, key_limit} > 6'(kvlt_pkg::KEY_CAPACITY - 1)) ?
                 6'(kvlt_pkg::KEY_CAPACITY - 1) : {1'b0, key_limit};
          r.data = c;
          r.pos  = key_count;
          if (key_count < klim) begin
            r.kind    = kvlt_pkg::KIND_KEY;
            key_count = key_count + 6'd1;
          end else begin
            r.kind = kvlt_pkg::KIND_OVERFLOW;
          end
        end else if (verdict == VD_TRUE && stage == ST_VALUE_BEGIN) begin
          vlim = ({1'b0, value_limit} > 7'(kvlt_pkg::VALUE_CAPACITY - 1)) ?
                 7'(kvlt_pkg::VALUE_CAPACITY - 1) : {1'b0, value_limit};
          r.data = c;
          r.pos  = value_count[5:0];
          if (value_count < vlim) begin
            r.kind      = kvlt_pkg::KIND_VALUE;
            value_count = value_count + 7'd1;
          end else begin
            r.kind = kvlt_pkg::KIND_OVERFLOW;
          end
        end
      end
      return r;
    endfunction

    function void note_byte(logic [7:0] c);
      pending_tokens.push_back(tokenize_byte(c));
    endfunction

    function int pending();
      return pending_tokens.size();
    endfunction

    function void check_result(kvlt_pkg::kind_t kind, logic [7:0] data, logic [5:0] pos);
      token_t want;
      if (pending_tokens.size() == 0) begin
        $display("%0t: result with nothing pending: kind %0d byte %h position %0d",
                 $time, kind, data, pos);
        errors++;
        return;
      end
      want = pending_tokens.pop_front();
      if (kind !== want.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
        errors++;
      end
      if (data !== want.data) begin
        $display("%0t: byte expected %h actual %h", $time, want.data, data);
        errors++;
      end
      if (pos !== want.pos) begin
        $display("%0t: position expected %0d actual %0d", $time, want.pos, pos);
        errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic                            cfg_index;
  logic [kvlt_pkg::CFG_DATA_W-1:0] cfg_data;

  kvlt_byte_if   byte_ch();
  kvlt_result_if result_ch();

  key_value_line_tokenizer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
  );

  tokenizer_scoreboard sb;
  logic [7:0]          line_q[$];
  int                  burst_left;
  bit                  hold_req;
  int                  cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("key_value_line_tokenizer_tb: done, errors");
    $finish;
  end

  // Receiver: the stall pattern steps through five modes in turn; a hold request
  // closes the output for a long stretch so the input side backs up.
  initial begin
    int rx_cycle;
    int hold_left;
    int mode;
    rx_cycle  = 0;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.kind, result_ch.byte_out, result_ch.position);
      rx_cycle++;
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        mode = (rx_cycle / 80) % 5;
        case (mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= 1'($urandom_range(0, 1));
          2: result_ch.ready <= ($urandom_range(0, 9) != 0);
          3: result_ch.ready <= ((rx_cycle % 4) == 0);
          default: result_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  task automatic offer(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        byte_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    byte_ch.valid   <= 1'b1;
    byte_ch.byte_in <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    sb.note_byte(b);
  endtask

  task automatic send_queued(output int count);
    logic [7:0] b;
    count = 0;
    while (line_q.size() > 0) begin
      b = line_q.pop_front();
      offer(b);
      count++;
    end
  endtask

  // Lowers valid and waits until every predicted result has been taken.
  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_limits(input int k, input int v);
    logic [5:0] kd;
    logic [5:0] vd;
    kd = 6'(k);
    vd = 6'(v);
    cfg_we    <= 1'b1;
    cfg_index <= kvlt_pkg::REG_KEY_LIMIT;
    cfg_data  <= kd;
    @(posedge clk);
    sb.set_limit(kvlt_pkg::REG_KEY_LIMIT, kd);
    cfg_index <= kvlt_pkg::REG_VALUE_LIMIT;
    cfg_data  <= vd;
    @(posedge clk);
    sb.set_limit(kvlt_pkg::REG_VALUE_LIMIT, vd);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_len(int cap);
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, cap + 8);
    return $urandom_range(1, 6);
  endfunction

  function automatic void put_word(int len);
    int r;
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 61);
      if (r < 10) c = 8'(8'h30 + r);
      else if (r < 36) c = 8'(8'h41 + (r - 10));
      else c = 8'(8'h61 + (r - 36));
      line_q.push_back(c);
    end
  endfunction

  function automatic void put_quoted(int cap);
    line_q.push_back(kvlt_pkg::CH_QUOTE);
    put_word(pick_len(cap));
    line_q.push_back(kvlt_pkg::CH_QUOTE);
  endfunction

  // Mostly well-formed lines of pairs, some with a nested object or array
  // value; the rest are noise, lines with one byte spoiled, or lines carrying
  // a carriage return or NUL before the line feed.
  function automatic void build_line();
    int         shape;
    int         pairs;
    int         inner;
    logic [7:0] open;
    shape = $urandom_range(0, 99);
    if (shape < 10) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      pairs = $urandom_range(1, 4);
      for (int i = 0; i < pairs; i++) begin
        if (i > 0) line_q.push_back(kvlt_pkg::CH_COMMA);
        put_quoted(31);
        line_q.push_back(kvlt_pkg::CH_COLON);
        if ($urandom_range(0, 4) == 0) begin
          open = $urandom_range(0, 1) ? kvlt_pkg::CH_LCURLY : kvlt_pkg::CH_LBRACK;
          line_q.push_back(open);
          inner = $urandom_range(1, 3);
          for (int j = 0; j < inner; j++) begin
            if (j > 0) line_q.push_back(kvlt_pkg::CH_COMMA);
            put_quoted(8);
            line_q.push_back(kvlt_pkg::CH_COLON);
            put_quoted(8);
          end
          line_q.push_back(open == kvlt_pkg::CH_LCURLY ? kvlt_pkg::CH_RCURLY
                                                       : kvlt_pkg::CH_RBRACK);
        end else begin
          put_quoted(63);
        end
      end
      if (shape < 22)
        line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
      else if (shape < 30)
        line_q.push_back($urandom_range(0, 1) ? kvlt_pkg::CH_CR : kvlt_pkg::CH_NUL);
    end
    line_q.push_back(kvlt_pkg::CH_LF);
  endfunction

  task automatic run_phase(input int k, input int v, input int n, input bit hold);
    int sent;
    int count;
    set_limits(k, v);
    if (hold) hold_req = 1'b1;
    sent = 0;
    while (sent < n) begin
      build_line();
      send_queued(count);
      sent += count;
    end
    drain();
  endtask

  initial begin
    string pattern;
    int    count;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= kvlt_pkg::REG_KEY_LIMIT;
    cfg_data        <= '0;
    byte_ch.valid   <= 1'b0;
    byte_ch.byte_in <= '0;
    hold_req   = 1'b0;
    burst_left = 0;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a plain pair, a nested array value that overflows and then
    // repeats the pair report on a stray byte, and a junk line of extreme
    // bytes that ends in a failed verdict.
    set_limits(1, 1);
    pattern = "\"ab\":\"c\"\n\"x\":[\"yz\"]!\n";
    for (int i = 0; i < pattern.len(); i++) line_q.push_back(pattern[i]);
    line_q.push_back(8'hFF);
    line_q.push_back(kvlt_pkg::CH_CR);
    line_q.push_back(kvlt_pkg::CH_NUL);
    line_q.push_back(kvlt_pkg::CH_LF);
    send_queued(count);
    drain();

    run_phase(31, 63, 90, 1'b0);
    run_phase(1, 63, 90, 1'b0);
    run_phase(31, 1, 90, 1'b1);
    run_phase($urandom_range(1, 31), $urandom_range(1, 63), 90, 1'b0);
    run_phase($urandom_range(1, 31), $urandom_range(1, 63), 90, 1'b0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("key_value_line_tokenizer_tb: done, clean");
    end else begin
      $display("key_value_line_tokenizer_tb: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/kvlt_pkg.sv
src/kvlt_if.sv
src/key_value_line_tokenizer.sv
bench/key_value_line_tokenizer_tb.sv
